>>> hdl/lr_pkg.sv
// shared types and constants for the line rasterizer
package lr_pkg;

    // coordinate and field widths
    localparam int COORD_BITS = 12;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 12;
    localparam int PITCH_W    = 13;
    localparam int ADDR_W     = 23;
    localparam int COLOUR_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [PITCH_W-1:0]  PITCH_RESET  = 13'd640;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH_WORDS = 2'd2;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // input item
    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOUR_W-1:0]          pixel_value;
    } item_t;

    // result item
    typedef struct packed {
        logic                pixel_valid;
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOUR_W-1:0] pixel_data;
        logic                last_pixel;
        logic                line_active;
    } result_t;

    // pixel request from the stepping stage to the address stage
    typedef struct packed {
        logic                         draw;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [COLOUR_W-1:0]          colour;
        logic                         last_pixel;
        logic                         line_active;
    } pix_req_t;

endpackage

>>> hdl/lr_pixel_stage.sv
// clip test and word address generation, feeding the result register
module lr_pixel_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lr_pkg::pix_req_t              req,
    input  logic [lr_pkg::WIDTH_W-1:0]    surface_width,
    input  logic [lr_pkg::HEIGHT_W-1:0]   surface_height,
    input  logic [lr_pkg::PITCH_W-1:0]    row_pitch_words,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lr_pkg::result_t               result
);

    localparam int CB     = lr_pkg::COORD_BITS;
    localparam int PROD_W = CB + lr_pkg::PITCH_W;
    localparam int CALC_W = (PROD_W + 1 > lr_pkg::ADDR_W) ? PROD_W + 1 : lr_pkg::ADDR_W;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    lr_pkg::result_t          result_reg;
    lr_pkg::result_t          result_next;
    logic [CB-1:0]            px_u;
    logic [CB-1:0]            py_u;
    logic                     in_bounds;
    logic [PROD_W-1:0]        row_base;
    logic [CALC_W-1:0]        addr_sum;

    // the result register takes a new transfer when empty or when drained
    assign req_stall = result_valid_reg && result_stall;

    // clip against the surface
    assign px_u      = req.px;
    assign py_u      = req.py;
    assign in_bounds = req.draw && !req.px[CB-1] && !req.py[CB-1]
                       && (px_u < surface_width) && (py_u < surface_height);

    // word address y * pitch + x
    assign row_base = py_u * row_pitch_words;
    assign addr_sum = CALC_W'(row_base) + CALC_W'(px_u);

    // result fields; address and data are zero when the pixel is suppressed
    always_comb
    begin
        result_valid_next         = result_valid_reg;
        result_next               = result_reg;
        if (!req_stall)
        begin
            result_valid_next         = req_valid;
            result_next.pixel_valid   = in_bounds;
            result_next.pixel_address = in_bounds ? addr_sum[lr_pkg::ADDR_W-1:0]
                                                  : '0;
            result_next.pixel_data    = in_bounds ? req.colour : '0;
            result_next.last_pixel    = req.last_pixel;
            result_next.line_active   = req.line_active;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hdl/line_rasterizer_core.sv
// line rasterizer top level: input register, line stepping state, pixel stage
//
// Bresenham line engine. An item on the item channel is either a load
// (two endpoints and a colour word) or a step. Every item gives exactly one
// transfer on the result channel: a load reports whether the line has any
// pixels, a step reports one pixel write (address y * pitch + x) or a
// suppressed off-surface pixel, plus last-pixel and line-active flags.
// Both channels are valid/stall; a transfer happens on a clock edge with
// valid high and stall low.
// An item transfer loads the input register, then the stepping stage, then
// the result register through the clip and address multiply-add. One item
// per cycle is sustained while the receiver does not stall; the stepping
// stage closes its error/position loop within its own registers.
// When the receiver stalls, the result register holds and the earlier
// stages keep filling until they are all occupied, then item_stall rises.
// Reset empties the pipeline, drops any line in progress and sets the
// surface to 640 x 480 with a pitch of 640 words. Surface registers are
// to be written through the cfg port only while the pipeline is empty;
// the user must ensure this, as the block itself does not enforce it.
module line_rasterizer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  lr_pkg::item_t                    item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lr_pkg::result_t                  result,
    input  logic                             cfg_write,
    input  logic [lr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CB = lr_pkg::COORD_BITS;
    localparam int DW = CB + 1;
    localparam int EW = CB + 2;

    // surface registers
    logic [lr_pkg::WIDTH_W-1:0]  surface_width_reg;
    logic [lr_pkg::HEIGHT_W-1:0] surface_height_reg;
    logic [lr_pkg::PITCH_W-1:0]  row_pitch_words_reg;

    // pipeline control
    logic              a_valid_reg;
    lr_pkg::item_t     a_item_reg;
    logic              a_free;
    logic              b_valid_reg;
    lr_pkg::pix_req_t  b_req_reg;
    lr_pkg::pix_req_t  b_req_next;
    logic              b_free;
    logic              pix_stall;

    // line state
    logic                   active_reg,       active_next;
    logic                   steep_reg,        steep_next;
    logic signed [CB-1:0]   major_pos_reg,    major_pos_next;
    logic signed [CB-1:0]   major_end_reg,    major_end_next;
    logic signed [CB-1:0]   minor_pos_reg,    minor_pos_next;
    logic                   minor_neg_reg,    minor_neg_next;
    logic [DW-1:0]          delta_major_reg,  delta_major_next;
    logic [DW-1:0]          delta_minor_reg,  delta_minor_next;
    logic signed [EW-1:0]   error_acc_reg,    error_acc_next;
    logic [lr_pkg::COLOUR_W-1:0] colour_reg,  colour_next;

    // load path temporaries
    logic signed [CB-1:0]   lx1, ly1, lx2, ly2;
    logic signed [CB-1:0]   sx1, sy1, sx2, sy2;
    logic signed [CB-1:0]   ox1, oy1, ox2, oy2;
    logic [DW-1:0]          adx, ady;
    logic                   load_steep;

    // step path temporaries
    logic signed [EW-1:0]   err_sum;
    logic signed [EW:0]     err_twice;
    logic signed [CB-1:0]   major_inc;

    // absolute difference of two signed coordinates
    function automatic logic [CB:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
        logic signed [CB:0] d;
        d = (CB+1)'(a) - (CB+1)'(b);
        return d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
    endfunction

    // surface register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg   <= lr_pkg::WIDTH_RESET;
            surface_height_reg  <= lr_pkg::HEIGHT_RESET;
            row_pitch_words_reg <= lr_pkg::PITCH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lr_pkg::REG_SURFACE_WIDTH:
                    surface_width_reg <= cfg_data[lr_pkg::WIDTH_W-1:0];
                lr_pkg::REG_SURFACE_HEIGHT:
                    surface_height_reg <= cfg_data[lr_pkg::HEIGHT_W-1:0];
                lr_pkg::REG_ROW_PITCH_WORDS:
                    row_pitch_words_reg <= cfg_data[lr_pkg::PITCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // stage occupancy and back pressure
    assign b_free     = !b_valid_reg || !pix_stall;
    assign a_free     = !a_valid_reg || b_free;
    assign item_stall = !a_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && item_valid)
        begin
            a_item_reg <= item;
        end
    end

    // load: swap axes for steep lines, order by the major axis
    always_comb
    begin
        lx1        = a_item_reg.start_x;
        ly1        = a_item_reg.start_y;
        lx2        = a_item_reg.end_x;
        ly2        = a_item_reg.end_y;
        adx        = abs_diff(lx1, lx2);
        ady        = abs_diff(ly1, ly2);
        load_steep = adx < ady;
        sx1        = load_steep ? ly1 : lx1;
        sy1        = load_steep ? lx1 : ly1;
        sx2        = load_steep ? ly2 : lx2;
        sy2        = load_steep ? lx2 : ly2;
        if (sx2 < sx1)
        begin
            ox1 = sx2;
            oy1 = sy2;
            ox2 = sx1;
            oy2 = sy1;
        end
        else
        begin
            ox1 = sx1;
            oy1 = sy1;
            ox2 = sx2;
            oy2 = sy2;
        end
    end

    // step: error update against twice the error
    assign err_sum   = error_acc_reg + $signed(EW'(delta_minor_reg));
    assign err_twice = {err_sum, 1'b0};
    assign major_inc = major_pos_reg + CB'(1);

    // next line state and pixel request
    always_comb
    begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        minor_neg_next   = minor_neg_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        error_acc_next   = error_acc_reg;
        colour_next      = colour_reg;
        b_req_next       = '0;

        if (a_item_reg.op == lr_pkg::OP_LOAD)
        begin
            steep_next       = load_steep;
            major_pos_next   = ox1;
            major_end_next   = ox2;
            minor_pos_next   = oy1;
            minor_neg_next   = !(oy2 > oy1);
            delta_major_next = DW'($signed(DW'(ox2)) - $signed(DW'(ox1)));
            delta_minor_next = abs_diff(oy1, oy2);
            error_acc_next   = '0;
            colour_next      = a_item_reg.pixel_value;
            active_next      = ox1 < ox2;
            b_req_next.line_active = ox1 < ox2;
        end
        else if (active_reg)
        begin
            b_req_next.draw   = 1'b1;
            b_req_next.px     = steep_reg ? minor_pos_reg : major_pos_reg;
            b_req_next.py     = steep_reg ? major_pos_reg : minor_pos_reg;
            b_req_next.colour = colour_reg;
            error_acc_next    = err_sum;
            if (err_twice >= $signed((EW+1)'(delta_major_reg)))
            begin
                minor_pos_next = minor_neg_reg ? minor_pos_reg - CB'(1)
                                               : minor_pos_reg + CB'(1);
                error_acc_next = err_sum - $signed(EW'(delta_major_reg));
            end
            major_pos_next = major_inc;
            if (major_inc >= major_end_reg)
            begin
                active_next           = 1'b0;
                b_req_next.last_pixel = 1'b1;
            end
            b_req_next.line_active = active_next;
        end
    end

    // stepping stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_neg_reg   <= 1'b0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            error_acc_reg   <= '0;
            colour_reg      <= '0;
        end
        else if (b_free)
        begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                active_reg      <= active_next;
                steep_reg       <= steep_next;
                major_pos_reg   <= major_pos_next;
                major_end_reg   <= major_end_next;
                minor_pos_reg   <= minor_pos_next;
                minor_neg_reg   <= minor_neg_next;
                delta_major_reg <= delta_major_next;
                delta_minor_reg <= delta_minor_next;
                error_acc_reg   <= error_acc_next;
                colour_reg      <= colour_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            b_req_reg <= b_req_next;
        end
    end

    // clip, address and result register
    lr_pixel_stage u_pixel_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (b_valid_reg),
        .req_stall       (pix_stall),
        .req             (b_req_reg),
        .surface_width   (surface_width_reg),
        .surface_height  (surface_height_reg),
        .row_pitch_words (row_pitch_words_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result)
    );

    // the final pixel of a line never reports further steps
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_pixel |-> !result.line_active)
        else $error("last pixel reported with line still active");

    // a live line keeps its error below half the major delta
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ($signed({error_acc_reg, 1'b0})
                        < $signed((EW+1)'(delta_major_reg))))
        else $error("line error out of range");

    // a held pixel request stays in the stepping stage
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && pix_stall |=> b_valid_reg && $stable(b_req_reg))
        else $error("pixel request lost under stall");

    // back pressure reaches the input only when the input register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> a_valid_reg && b_valid_reg && result_valid)
        else $error("input stalled with a free stage");

endmodule
